[rtl/dlcbf_pkg.sv]
// Package: types, constants and codes of the d-left counting Bloom filter.
`default_nettype none
package dlcbf_pkg;
    localparam int          SUBTABLES_DEF        = 4;
    localparam int          INDEX_BITS_DEF       = 10;
    localparam int          BUCKET_CELLS_DEF     = 8;
    localparam int          FINGERPRINT_BITS_DEF = 12;
    localparam int          COUNTER_BITS_DEF     = 4;
    localparam logic [31:0] FNV_BASIS            = 32'd2166136261;
    localparam logic [31:0] FNV_MULT             = 32'd16777619;
    localparam logic [31:0] MULT_RESET           = 32'd2654435761;

    typedef enum logic [1:0] {
        REQ_QUERY  = 2'd0,
        REQ_ADD    = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_UNDEF  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_FULL     = 3'd2,
        ST_REMOVED  = 3'd3,
        ST_ABSENT   = 3'd4,
        ST_QPRESENT = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PERM,
        S_READ,
        S_EVAL,
        S_DECIDE,
        S_WRITE,
        S_RESULT
    } t_state;
endpackage
`default_nettype wire

[rtl/dlcbf_if.sv]
// Valid/ready channel interfaces for key bytes, results and configuration.
`default_nettype none
interface dlcbf_key_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] key_byte;
    logic       key_last;
    modport source (output valid, req_type, key_byte, key_last, input ready);
    modport sink   (input valid, req_type, key_byte, key_last, output ready);
endinterface

interface dlcbf_res_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [2:0] status;
    modport source (output valid, found, status, input ready);
    modport sink   (input valid, found, status, output ready);
endinterface

interface dlcbf_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

[rtl/dlcbf_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module dlcbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[rtl/dleft_counting_bloom_filter_unit.sv]
// d-left counting Bloom filter: FNV-1a key hash, bucket read-modify-write in one RAM.
// A non-last byte is accepted in S_IDLE and folded into the hash by a 32x32 multiply in S_HASH.
// A last byte's result follows its transfer through hash, a permute per subtable, scan and
// rewrite walks of one cell per cycle, evaluate, decide and result.
// One key at a time, set by the single cell RAM; the next byte waits until the result is taken.
// Reset runs a clearing pass over all SUBTABLES*2^INDEX_BITS*BUCKET_CELLS cells; no byte before.
`default_nettype none
module dleft_counting_bloom_filter_unit #(
    parameter int SUBTABLES        = dlcbf_pkg::SUBTABLES_DEF,
    parameter int INDEX_BITS       = dlcbf_pkg::INDEX_BITS_DEF,
    parameter int BUCKET_CELLS     = dlcbf_pkg::BUCKET_CELLS_DEF,
    parameter int FINGERPRINT_BITS = dlcbf_pkg::FINGERPRINT_BITS_DEF,
    parameter int COUNTER_BITS     = dlcbf_pkg::COUNTER_BITS_DEF
) (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    dlcbf_key_if.sink   i_key,
    dlcbf_res_if.source o_res,
    dlcbf_cfg_if.sink   i_cfg
);
    import dlcbf_pkg::*;

    localparam int TB    = (SUBTABLES > 1) ? $clog2(SUBTABLES) : 1;
    localparam int CB    = (BUCKET_CELLS > 1) ? $clog2(BUCKET_CELLS) : 1;
    localparam int CC    = $clog2(BUCKET_CELLS + 1);
    localparam int DEPTH = SUBTABLES * (2 ** INDEX_BITS) * BUCKET_CELLS;
    localparam int AB    = $clog2(DEPTH);
    localparam int W     = FINGERPRINT_BITS + COUNTER_BITS;
    localparam logic [TB-1:0] T_LAST = TB'(SUBTABLES - 1);
    localparam logic [CB-1:0] C_LAST = CB'(BUCKET_CELLS - 1);

    t_state r_state, n_state;
    logic [31:0] r_mult, r_hash, r_h;
    logic [1:0]  r_req;
    logic [INDEX_BITS-1:0]       r_idx [SUBTABLES];
    logic [FINGERPRINT_BITS-1:0] r_fp  [SUBTABLES];
    logic [CC-1:0]   r_load [SUBTABLES];
    logic [TB-1:0]   r_t;
    logic [CB-1:0]   r_c;
    logic            r_rd_v;
    logic [TB-1:0]   r_rd_t;
    logic [CB-1:0]   r_rd_c;
    logic [AB-1:0]   r_clr;
    logic            r_found, r_done;
    logic            r_best_v;
    logic [CB-1:0]   r_free [SUBTABLES];
    logic [SUBTABLES-1:0] r_free_v;
    logic            r_out_v, r_out_found;
    logic [2:0]      r_out_st;

    logic [TB-1:0]   best_t;
    logic [CC-1:0]   best_load;
    logic            best_v;
    logic            we;
    logic [AB-1:0]   waddr, raddr;
    logic [W-1:0]    wdata, rdata;
    logic [FINGERPRINT_BITS-1:0] rd_fp;
    logic [COUNTER_BITS-1:0]     rd_cnt;
    logic            rd_match;
    logic [AB-1:0]   r_wa;
    logic [31:0]     prod;
    logic [31:0]     mul_a, mul_b;

    function automatic logic [AB-1:0] addr_of(input logic [TB-1:0] t,
            input logic [INDEX_BITS-1:0] idx, input logic [CB-1:0] c);
        logic [AB+TB-1:0] a;
        a = ((AB+TB)'(t) * (AB+TB)'(2 ** INDEX_BITS) + (AB+TB)'(idx))
            * (AB+TB)'(BUCKET_CELLS) + (AB+TB)'(c);
        return a[AB-1:0];
    endfunction

    assign i_cfg.ready = 1'b1;
    assign i_key.ready = (r_state == S_IDLE) && !r_out_v;
    assign o_res.valid = r_out_v;
    assign o_res.found = r_out_found;
    assign o_res.status = r_out_st;

    assign mul_a = (r_state == S_PERM) ? r_h : r_hash;
    assign mul_b = (r_state == S_PERM) ? r_mult : FNV_MULT;
    assign prod  = mul_a * mul_b;

    assign {rd_fp, rd_cnt} = rdata;
    assign rd_match = (rd_cnt != '0) && (rd_fp == r_fp[r_rd_t]);

    always_comb begin
        best_t = '0;
        best_load = CC'(BUCKET_CELLS);
        best_v = 1'b0;
        for (int t = 0; t < SUBTABLES; t++) begin
            if (r_load[t] < best_load) begin
                best_load = r_load[t];
                best_t = TB'(t);
                best_v = 1'b1;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_clr == AB'(DEPTH - 1)) n_state = S_IDLE;
            S_IDLE:   if (i_key.valid && i_key.ready) n_state = S_HASH;
            S_HASH:   n_state = r_done ? S_PERM : S_IDLE;
            S_PERM:   if (r_t == T_LAST) n_state = S_READ;
            S_READ:   if (r_t == T_LAST && r_c == C_LAST) n_state = S_EVAL;
            S_EVAL:   n_state = S_DECIDE;
            S_DECIDE: n_state = S_WRITE;
            S_WRITE:  if (r_t == T_LAST && r_c == C_LAST) n_state = S_RESULT;
            S_RESULT: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // RAM control
    always_comb begin
        we = 1'b0;
        waddr = r_wa;
        wdata = '0;
        raddr = addr_of(r_t, r_idx[r_t], r_c);
        unique case (r_state)
            S_CLEAR: begin
                we = 1'b1;
                waddr = r_clr;
            end
            S_WRITE, S_RESULT: begin
                // removal rewrites each matching cell as it is read back
                if (r_req == REQ_REMOVE && r_found && r_rd_v && rd_match) begin
                    we = 1'b1;
                    wdata = (rd_cnt == COUNTER_BITS'(1)) ? '0
                            : {rd_fp, rd_cnt - COUNTER_BITS'(1)};
                end
            end
            S_DECIDE: begin
                if (r_req == REQ_ADD && !r_found && best_v) begin
                    we = 1'b1;
                    waddr = addr_of(best_t, r_idx[best_t], r_free[best_t]);
                    wdata = {r_fp[best_t], COUNTER_BITS'(1)};
                end
            end
            default: ;
        endcase
    end

    dlcbf_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_cells (
        .i_clk, .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_mult  <= MULT_RESET;
            r_hash  <= FNV_BASIS;
            r_clr   <= '0;
            r_out_v <= 1'b0;
            r_rd_v  <= 1'b0;
            r_t     <= '0;
            r_c     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) r_mult <= i_cfg.data;
            if (o_res.valid && o_res.ready) r_out_v <= 1'b0;
            r_rd_v <= 1'b0;
            r_rd_t <= r_t;
            r_rd_c <= r_c;
            r_wa   <= raddr;
            unique case (r_state)
                S_CLEAR: r_clr <= r_clr + AB'(1);
                S_IDLE: begin
                    if (i_key.valid && i_key.ready) begin
                        r_hash <= r_hash ^ {24'd0, i_key.key_byte};
                        r_done <= i_key.key_last;
                        r_req  <= i_key.req_type;
                    end
                end
                S_HASH: begin
                    if (r_done) begin
                        r_h    <= prod;
                        r_hash <= FNV_BASIS;
                    end else begin
                        r_hash <= prod;
                    end
                    r_t <= '0;
                end
                S_PERM: begin
                    r_h <= prod;
                    r_idx[r_t] <= prod[31 -: INDEX_BITS];
                    r_fp[r_t]  <= prod[FINGERPRINT_BITS-1:0];
                    r_load[r_t] <= '0;
                    r_free_v[r_t] <= 1'b0;
                    r_found <= 1'b0;
                    r_t <= (r_t == T_LAST) ? '0 : r_t + TB'(1);
                    r_c <= '0;
                end
                S_READ, S_WRITE: begin
                    r_rd_v <= 1'b1;
                    if (r_c == C_LAST) begin
                        r_c <= '0;
                        r_t <= (r_t == T_LAST) ? '0 : r_t + TB'(1);
                    end else begin
                        r_c <= r_c + CB'(1);
                    end
                end
                default: ;
            endcase
            // consume read data of the scan pass
            if ((r_state == S_READ || r_state == S_EVAL) && r_rd_v) begin
                if (rd_match) r_found <= 1'b1;
                if (rd_cnt != '0) begin
                    r_load[r_rd_t] <= r_load[r_rd_t] + CC'(1);
                end else if (!r_free_v[r_rd_t]) begin
                    r_free_v[r_rd_t] <= 1'b1;
                    r_free[r_rd_t] <= r_rd_c;
                end
            end
            if (r_state == S_DECIDE) begin
                r_best_v <= best_v;
                r_t <= '0;
                r_c <= '0;
            end
            if (r_state == S_RESULT) begin
                r_out_v <= 1'b1;
                r_out_found <= r_found;
                case (r_req)
                    REQ_ADD:    r_out_st <= r_found ? ST_PRESENT
                                          : (r_best_v ? ST_INSERTED : ST_FULL);
                    REQ_REMOVE: r_out_st <= r_found ? ST_REMOVED : ST_ABSENT;
                    default:    r_out_st <= r_found ? ST_QPRESENT : ST_ABSENT;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

[rtl/dlcbf_checker.sv]
// Port-level checker for the filter unit, bound to its top level.
`default_nettype none
module dlcbf_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       kr, rv, rr, rf,
    input wire logic [2:0] rs
);
    import dlcbf_pkg::*;

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rv && !rr |=> rv && $stable(rs) && $stable(rf)) else $error("result dropped");
    a_status_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rv |-> rs <= ST_QPRESENT) else $error("bad status");
    a_found_st: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rv && rf |-> (rs == ST_PRESENT || rs == ST_REMOVED || rs == ST_QPRESENT))
        else $error("found mismatch");
    a_nofound_st: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rv && !rf |-> (rs == ST_INSERTED || rs == ST_FULL || rs == ST_ABSENT))
        else $error("absent mismatch");
    a_no_accept_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rv |-> !kr) else $error("accepted with result pending");
endmodule

bind dleft_counting_bloom_filter_unit dlcbf_checker u_chk (
    .i_clk, .i_rst_n, .kr(i_key.ready), .rv(o_res.valid),
    .rr(o_res.ready), .rf(o_res.found), .rs(o_res.status)
);
`default_nettype wire

[tb/sv/tb_dleft_counting_bloom_filter_unit.sv]
// Testbench for the d-left counting Bloom filter unit: directed and random keys checked against a predictor.
`default_nettype none
module tb_dleft_counting_bloom_filter_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import dlcbf_pkg::*;

    localparam int NT = SUBTABLES_DEF;
    localparam int NI = INDEX_BITS_DEF;
    localparam int NC = BUCKET_CELLS_DEF;
    localparam int FPB = FINGERPRINT_BITS_DEF;
    localparam int CELLS = (NT << NI) * NC;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic    found;
        t_status status;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    dlcbf_key_if key_if ();
    dlcbf_res_if res_if ();
    dlcbf_cfg_if cfg_if ();

    dleft_counting_bloom_filter_unit i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_key  (key_if),
        .o_res  (res_if),
        .i_cfg  (cfg_if)
    );

    // Filter state mirror
    logic [31:0]    mult_shadow;
    logic [31:0]    hash_acc;
    logic [FPB-1:0] fp_mem  [CELLS];
    logic [3:0]     cnt_mem [CELLS];
    t_result        pending_results[$];

    int mismatches;
    int send_idle_pct;
    int recv_stall_pct;
    int recv_hold;

    // Key pool used by the random phases
    logic [31:0] pool_data [32];
    int          pool_len  [32];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

    function automatic int cell_idx(int t, logic [NI-1:0] idx, int c);
        return ((t << NI) + int'(idx)) * NC + c;
    endfunction

    function automatic logic [31:0] fnv_of(logic [31:0] data, int len);
        logic [31:0] h;
        h = FNV_BASIS;
        for (int i = 0; i < len; i++) begin
            h = (h ^ {24'd0, data[8*i +: 8]}) * FNV_MULT;
        end
        return h;
    endfunction

    // Fold one byte; on the last byte serve the request and queue its result.
    function automatic void predict_byte(logic [1:0] req, logic [7:0] b, logic last);
        logic [31:0]    h;
        logic [NI-1:0]  idx [NT];
        logic [FPB-1:0] fpk [NT];
        logic           hit;
        int             best;
        int             best_load;
        int             load;
        int             k;
        t_result        r;
        hash_acc = (hash_acc ^ {24'd0, b}) * FNV_MULT;
        if (!last) return;
        h = hash_acc;
        hash_acc = FNV_BASIS;
        hit = 1'b0;
        for (int t = 0; t < NT; t++) begin
            h = h * mult_shadow;
            idx[t] = h[31 -: NI];
            fpk[t] = h[FPB-1:0];
            for (int c = 0; c < NC; c++) begin
                k = cell_idx(t, idx[t], c);
                if (cnt_mem[k] != 0 && fp_mem[k] == fpk[t]) hit = 1'b1;
            end
        end
        r.found = hit;
        case (req)
            REQ_ADD: begin
                if (hit) begin
                    r.status = ST_PRESENT;
                end else begin
                    best = -1;
                    best_load = NC;
                    for (int t = 0; t < NT; t++) begin
                        load = 0;
                        for (int c = 0; c < NC; c++)
                            if (cnt_mem[cell_idx(t, idx[t], c)] != 0) load++;
                        if (load < best_load) begin
                            best_load = load;
                            best = t;
                        end
                    end
                    if (best < 0) begin
                        r.status = ST_FULL;
                    end else begin
                        for (int c = 0; c < NC; c++) begin
                            k = cell_idx(best, idx[best], c);
                            if (cnt_mem[k] == 0) begin
                                fp_mem[k]  = fpk[best];
                                cnt_mem[k] = 4'd1;
                                break;
                            end
                        end
                        r.status = ST_INSERTED;
                    end
                end
            end
            REQ_REMOVE: begin
                if (hit) begin
                    for (int t = 0; t < NT; t++) begin
                        for (int c = 0; c < NC; c++) begin
                            k = cell_idx(t, idx[t], c);
                            if (cnt_mem[k] != 0 && fp_mem[k] == fpk[t]) begin
                                cnt_mem[k] = cnt_mem[k] - 4'd1;
                                if (cnt_mem[k] == 0) fp_mem[k] = '0;
                            end
                        end
                    end
                    r.status = ST_REMOVED;
                end else begin
                    r.status = ST_ABSENT;
                end
            end
            default: r.status = hit ? ST_QPRESENT : ST_ABSENT;
        endcase
        pending_results.push_back(r);
    endfunction

    // Drive one byte and hold it until the transfer; valid stays high afterwards.
    task automatic send_byte(logic [1:0] req, logic [7:0] b, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            key_if.valid = 1'b0;
            @(negedge i_clk);
        end
        key_if.valid    = 1'b1;
        key_if.req_type = req;
        key_if.key_byte = b;
        key_if.key_last = last;
        @(posedge i_clk);
        while (!key_if.ready) @(posedge i_clk);
        predict_byte(req, b, last);
        @(negedge i_clk);
    endtask

    // Only the request type on the last byte counts; scramble it on the others.
    task automatic send_key(t_req req, logic [31:0] data, int len);
        for (int i = 0; i < len; i++) begin
            if (i == len - 1) send_byte(req, data[8*i +: 8], 1'b1);
            else send_byte(2'($urandom_range(3)), data[8*i +: 8], 1'b0);
        end
        key_if.valid = 1'b0;
    endtask

    task automatic wait_drained();
        key_if.valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_mult(logic [31:0] value);
        cfg_if.valid = 1'b1;
        cfg_if.data  = value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        mult_shadow = value;
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    // Receiver: random stall, or a long hold-off counted down here.
    always @(negedge i_clk) begin
        if (recv_hold > 0) begin
            res_if.ready <= 1'b0;
            recv_hold    <= recv_hold - 1;
        end else begin
            res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: found=%0b status=%0d",
                             res_if.found, res_if.status);
            end else begin
                exp_r = pending_results.pop_front();
                if (res_if.found !== exp_r.found || res_if.status !== exp_r.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected found=%0b status=%0d, got found=%0b status=%0d",
                                 exp_r.found, exp_r.status, res_if.found, res_if.status);
                end
            end
        end
    end

    task automatic test_basic_ops();
        send_key(REQ_QUERY, 32'h0000_0000, 1);
        send_key(REQ_ADD, 32'h0000_0000, 1);
        send_key(REQ_ADD, 32'h0000_0000, 1);
        send_key(REQ_QUERY, 32'h0000_0000, 1);
        send_key(REQ_UNDEF, 32'h0000_0000, 1);
        send_key(REQ_ADD, 32'hFFFF_FFFF, 4);
        send_key(REQ_REMOVE, 32'h0000_0000, 1);
        send_key(REQ_REMOVE, 32'h0000_0000, 1);
        send_key(REQ_UNDEF, 32'h0000_00FF, 1);
        send_key(REQ_QUERY, 32'hFFFF_FFFF, 4);
        send_key(REQ_REMOVE, 32'hFFFF_FFFF, 4);
        wait_drained();
    endtask

    // Multiplier 1 gives every subtable the same bucket; fill it until full.
    task automatic test_table_full();
        logic [31:0]    cand;
        logic [31:0]    h;
        logic [NI-1:0]  target;
        logic [FPB-1:0] used [$];
        logic [31:0]    keys [$];
        logic           dup;
        write_mult(32'd1);
        cand   = $urandom;
        h      = fnv_of(cand, 4);
        target = h[31 -: NI];
        while (keys.size() < NT * NC + 2) begin
            cand = $urandom;
            h    = fnv_of(cand, 4);
            if (h[31 -: NI] == target) begin
                dup = 1'b0;
                foreach (used[i]) if (used[i] == h[FPB-1:0]) dup = 1'b1;
                if (!dup) begin
                    used.push_back(h[FPB-1:0]);
                    keys.push_back(cand);
                end
            end
        end
        foreach (keys[i]) send_key(REQ_ADD, keys[i], 4);
        send_key(REQ_REMOVE, keys[0], 4);
        send_key(REQ_ADD, keys[NT*NC+1], 4);
        wait_drained();
    endtask

    task automatic test_mult_extremes();
        write_mult(32'hFFFF_FFFF);
        send_key(REQ_ADD, 32'h0000_1234, 2);
        send_key(REQ_QUERY, 32'h0000_1234, 2);
        wait_drained();
        write_mult(32'd2);
        send_key(REQ_ADD, 32'h00AB_CDEF, 3);
        send_key(REQ_REMOVE, 32'h00AB_CDEF, 3);
        wait_drained();
    endtask

    task automatic run_random_phase(int idle_pct, int stall_pct, int nkeys, int hold);
        int   sel;
        int   pick;
        t_req req;
        wait_drained();
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        write_mult({$urandom} | 32'd1);
        foreach (pool_data[i]) begin
            pool_data[i] = $urandom;
            pool_len[i]  = $urandom_range(1, 4);
        end
        if (hold > 0) recv_hold = hold;
        for (int n = 0; n < nkeys; n++) begin
            sel = $urandom_range(99);
            if (sel < 40) req = REQ_ADD;
            else if (sel < 70) req = REQ_REMOVE;
            else if (sel < 95) req = REQ_QUERY;
            else req = REQ_UNDEF;
            if ($urandom_range(9) == 0) begin
                send_key(req, $urandom, $urandom_range(1, 4));
            end else begin
                pick = $urandom_range(31);
                send_key(req, pool_data[pick], pool_len[pick]);
            end
            if (n == nkeys / 2) wait_drained();
        end
        wait_drained();
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, 0, 160, 400);
        run_random_phase(45, 0, 160, 0);
        run_random_phase(0, 45, 160, 0);
        run_random_phase(19, 19, 160, 0);
    endtask

    initial begin
        mismatches      = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        recv_hold       = 0;
        mult_shadow     = MULT_RESET;
        hash_acc        = FNV_BASIS;
        for (int k = 0; k < CELLS; k++) begin
            fp_mem[k]  = '0;
            cnt_mem[k] = '0;
        end
        key_if.valid    = 1'b0;
        key_if.req_type = REQ_QUERY;
        key_if.key_byte = 8'd0;
        key_if.key_last = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.data     = 32'd0;
        res_if.ready    = 1'b0;
        i_rst_n         = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_basic_ops();
        test_table_full();
        test_mult_extremes();
        test_random_traffic();
        write_mult(MULT_RESET);
        send_key(REQ_QUERY, 32'h0000_0042, 1);
        wait_drained();

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
